[src/uyvy_pkg.sv]
// Package with item types, BT.709 fixed-point coefficients and arithmetic helpers.
package uyvy_pkg;

    localparam int CoefW = 23;
    localparam int OffsW = 9;
    localparam int ProdW = 30;
    localparam int AccW  = 32;
    localparam int FracW = 20;

    typedef logic signed [CoefW-1:0] t_coef;
    typedef logic signed [OffsW-1:0] t_offs;
    typedef logic signed [ProdW-1:0] t_prod;
    typedef logic signed [AccW-1:0]  t_acc;

    localparam t_coef KY  = 23'sd1220945;
    localparam t_coef KRV = 23'sd1879825;
    localparam t_coef KGU = -23'sd223607;
    localparam t_coef KGV = -23'sd558796;
    localparam t_coef KBU = 23'sd2215014;

    localparam t_offs LumaOfs   = 9'sd16;
    localparam t_offs ChromaOfs = 9'sd128;
    localparam t_acc  RoundHalf = t_acc'(1) <<< (FracW - 1);

    localparam logic [7:0] ChanMax     = 8'd255;
    localparam logic [7:0] AlphaOpaque = 8'd255;

    typedef struct packed {
        logic [7:0] cb_sample;
        logic [7:0] luma_first;
        logic [7:0] cr_sample;
        logic [7:0] luma_second;
    } t_in_item;

    typedef struct packed {
        logic [7:0] blue_first;
        logic [7:0] green_first;
        logic [7:0] red_first;
        logic [7:0] alpha_first;
        logic [7:0] blue_second;
        logic [7:0] green_second;
        logic [7:0] red_second;
        logic [7:0] alpha_second;
    } t_out_item;

    typedef struct packed {
        t_prod bu;
        t_prod gu;
        t_prod gv;
        t_prod rv;
    } t_chroma_prod;

    typedef struct packed {
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } t_pixel;

    function automatic t_offs remove_offset(input logic [7:0] x, input t_offs ofs);
        return $signed({1'b0, x}) - ofs;
    endfunction

    function automatic t_prod mul_coef(input t_coef coef, input t_offs offs);
        t_prod a;
        t_prod b;
        a = t_prod'(coef);
        b = t_prod'(offs);
        return a * b;
    endfunction

    function automatic logic [7:0] round_clamp(input t_acc acc);
        t_acc t;
        logic [AccW-FracW-1:0] q;
        t = acc + RoundHalf;
        q = t[AccW-1:FracW];
        if (t[AccW-1]) begin
            return 8'd0;
        end else if (|q[AccW-FracW-1:8]) begin
            return ChanMax;
        end else begin
            return q[7:0];
        end
    endfunction

endpackage

[src/uyvy_chroma.sv]
// Shared chroma products of one macropixel, registered for both pixel lanes.
module uyvy_chroma (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [7:0]             i_cb,
    input  logic [7:0]             i_cr,
    output uyvy_pkg::t_chroma_prod o_prod
);

    uyvy_pkg::t_offs        u;
    uyvy_pkg::t_offs        v;
    uyvy_pkg::t_chroma_prod n_prod;
    uyvy_pkg::t_chroma_prod r_prod;

    always_comb begin
        u         = uyvy_pkg::remove_offset(i_cb, uyvy_pkg::ChromaOfs);
        v         = uyvy_pkg::remove_offset(i_cr, uyvy_pkg::ChromaOfs);
        n_prod.bu = uyvy_pkg::mul_coef(uyvy_pkg::KBU, u);
        n_prod.gu = uyvy_pkg::mul_coef(uyvy_pkg::KGU, u);
        n_prod.gv = uyvy_pkg::mul_coef(uyvy_pkg::KGV, v);
        n_prod.rv = uyvy_pkg::mul_coef(uyvy_pkg::KRV, v);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

[src/uyvy_lane.sv]
// One pixel lane: luma product, then matrix sums with rounding and clamping.
module uyvy_lane (
    input  logic                   i_clk,
    input  logic                   i_en_mul,
    input  logic                   i_en_sum,
    input  logic [7:0]             i_luma,
    input  uyvy_pkg::t_chroma_prod i_chroma,
    output uyvy_pkg::t_pixel       o_pixel
);

    uyvy_pkg::t_prod  r_base;
    uyvy_pkg::t_acc   base;
    uyvy_pkg::t_pixel n_pixel;
    uyvy_pkg::t_pixel r_pixel;

    always_ff @(posedge i_clk) begin
        if (i_en_mul) begin
            r_base <= uyvy_pkg::mul_coef(uyvy_pkg::KY,
                uyvy_pkg::remove_offset(i_luma, uyvy_pkg::LumaOfs));
        end
    end

    always_comb begin
        base          = uyvy_pkg::t_acc'(r_base);
        n_pixel.blue  = uyvy_pkg::round_clamp(base + uyvy_pkg::t_acc'(i_chroma.bu));
        n_pixel.green = uyvy_pkg::round_clamp(base + uyvy_pkg::t_acc'(i_chroma.gu)
                                              + uyvy_pkg::t_acc'(i_chroma.gv));
        n_pixel.red   = uyvy_pkg::round_clamp(base + uyvy_pkg::t_acc'(i_chroma.rv));
    end

    always_ff @(posedge i_clk) begin
        if (i_en_sum) begin
            r_pixel <= n_pixel;
        end
    end

    assign o_pixel = r_pixel;

endmodule

[src/uyvy_merge.sv]
// Merges the two lane pixels into one BGRA item behind an output register and skid stage.
module uyvy_merge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  uyvy_pkg::t_pixel    i_first,
    input  uyvy_pkg::t_pixel    i_second,
    output logic                o_valid,
    input  logic                i_stall,
    output uyvy_pkg::t_out_item o_item
);

    uyvy_pkg::t_out_item merged;
    uyvy_pkg::t_out_item r_out;
    uyvy_pkg::t_out_item r_skid;
    logic                r_out_valid;
    logic                r_skid_valid;

    always_comb begin
        merged.blue_first   = i_first.blue;
        merged.green_first  = i_first.green;
        merged.red_first    = i_first.red;
        merged.alpha_first  = uyvy_pkg::AlphaOpaque;
        merged.blue_second  = i_second.blue;
        merged.green_second = i_second.green;
        merged.red_second   = i_second.red;
        merged.alpha_second = uyvy_pkg::AlphaOpaque;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || !i_stall) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid <= i_valid;
            end
        end else if (i_valid && !r_skid_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || !i_stall) begin
            r_out <= r_skid_valid ? r_skid : merged;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= merged;
        end
    end

    assign o_stall = r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_item  = r_out;

endmodule

[src/uyvy_to_bgra_bt709.sv]
// Top level of the UYVY 4:2:2 to BGRA converter with the BT.709 matrix.
//
//   Channel  Direction  Handshake           Item
//   input    in         i_valid / o_stall   one UYVY macropixel (t_in_item)
//   output   out        o_valid / i_stall   two BGRA pixels (t_out_item)
//
// One item is accepted per clock while o_stall is low; a taken item passes the multiplier,
// sum and merge output registers in that order; the multiplier and sum stages are pipelined.
// Reset clears the valid bits of the pipeline and of the output and skid registers.
// An output stall is absorbed by the skid register; o_stall rises only when it is full.
module uyvy_to_bgra_bt709 (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  uyvy_pkg::t_in_item  i_item,
    output logic                o_valid,
    input  logic                i_stall,
    output uyvy_pkg::t_out_item o_item
);

    logic                   r_valid_mul;
    logic                   r_valid_sum;
    logic                   merge_stall;
    logic                   en_mul;
    logic                   en_sum;
    uyvy_pkg::t_chroma_prod chroma;
    uyvy_pkg::t_pixel       pix_first;
    uyvy_pkg::t_pixel       pix_second;

    assign en_sum  = !r_valid_sum || !merge_stall;
    assign en_mul  = !r_valid_mul || en_sum;
    assign o_stall = !en_mul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_mul <= 1'b0;
            r_valid_sum <= 1'b0;
        end else begin
            if (en_mul) begin
                r_valid_mul <= i_valid;
            end
            if (en_sum) begin
                r_valid_sum <= r_valid_mul;
            end
        end
    end

    uyvy_chroma u_chroma (
        .i_clk  (i_clk),
        .i_en   (en_mul),
        .i_cb   (i_item.cb_sample),
        .i_cr   (i_item.cr_sample),
        .o_prod (chroma)
    );

    uyvy_lane u_lane_first (
        .i_clk    (i_clk),
        .i_en_mul (en_mul),
        .i_en_sum (en_sum),
        .i_luma   (i_item.luma_first),
        .i_chroma (chroma),
        .o_pixel  (pix_first)
    );

    uyvy_lane u_lane_second (
        .i_clk    (i_clk),
        .i_en_mul (en_mul),
        .i_en_sum (en_sum),
        .i_luma   (i_item.luma_second),
        .i_chroma (chroma),
        .o_pixel  (pix_second)
    );

    uyvy_merge u_merge (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (r_valid_sum),
        .o_stall  (merge_stall),
        .i_first  (pix_first),
        .i_second (pix_second),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_item   (o_item)
    );

endmodule
